// ===== design/set_union_dedup_engine_macros.svh =====
// Assertion macros used by the checker file of the union engine
`ifndef SET_UNION_DEDUP_ENGINE_MACROS_SVH
`define SET_UNION_DEDUP_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define SUD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SUD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sud_pkg.sv =====
package sud_pkg;

    // Sizes
    localparam int DEF_CAPACITY = 64;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 6;
    localparam int UCNT_W       = 7;
    localparam int CMD_W        = 2;
    localparam int QUEUE_DEPTH  = 2;

    // Command codes on i_cmd
    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIRST  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SECOND = 2'd2;

    // Classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_FIRST,
        OP_SECOND
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [VALUE_W-1:0] value;
    } t_qent;

    // Back-end sequencer states
    typedef enum logic [0:0] {
        BS_IDLE,
        BS_SCAN
    } t_bstate;

endpackage

// ===== design/sud_front.sv =====
module sud_front
    import sud_pkg::*;
(
    input  logic               i_start,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [VALUE_W-1:0] i_item_value,
    input  logic               i_q_full,
    output logic               o_busy,
    output logic               o_push,
    output t_qent              o_entry
);

    logic w_known;
    t_op  w_op;

    // Decode the command; the unused code is taken and dropped
    always_comb begin
        w_known = 1'b1;
        w_op    = OP_CLEAR;
        unique case (i_cmd)
            CMD_START:  w_op = OP_CLEAR;
            CMD_FIRST:  w_op = OP_FIRST;
            CMD_SECOND: w_op = OP_SECOND;
            default:    w_known = 1'b0;
        endcase
    end

    // Hold off new items only while the queue has no room
    assign o_busy        = i_q_full;
    assign o_push        = i_start && !i_q_full && w_known;
    assign o_entry.op    = w_op;
    assign o_entry.value = i_item_value;

endmodule

// ===== design/sud_queue.sv =====
module sud_queue
    import sud_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_entry,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_qent o_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_qent            r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_fill == CNT_W'(QUEUE_DEPTH));
    assign o_valid   = (r_fill != '0);
    assign o_entry   = r_slot[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Pointer and fill-level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_fill = r_fill + CNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_fill = r_fill - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Slot storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== design/sud_back.sv =====
module sud_back
    import sud_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_qent              i_q_entry,
    output logic               o_pop,
    output logic               o_result_valid,
    output logic [VALUE_W-1:0] o_out_value,
    output logic [POS_W-1:0]   o_out_position,
    output logic [UCNT_W-1:0]  o_union_count,
    output logic               o_store_full
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);

    // Entry store, one write port (insert) and one read port (scan)
    logic [VALUE_W-1:0] r_mem [CAPACITY];
    logic [VALUE_W-1:0] r_rd_data;

    t_bstate            r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_rd_vld, n_rd_vld;
    logic [VALUE_W-1:0] r_value, n_value;

    logic               r_res_vld, n_res_vld;
    logic [VALUE_W-1:0] r_res_value, n_res_value;
    logic [POS_W-1:0]   r_res_pos, n_res_pos;
    logic [UCNT_W-1:0]  r_res_cnt, n_res_cnt;
    logic               r_res_full, n_res_full;

    logic               w_ins;
    logic [VALUE_W-1:0] w_ins_value;
    logic               w_wr_en;
    logic [31:0]        w_cnt_ext;
    logic [31:0]        w_inc_ext;

    assign w_cnt_ext = 32'(r_count);
    assign w_inc_ext = 32'(r_count) + 32'd1;

    // Sequencer: pop, scan for a match, insert and emit
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_value     = r_value;
        n_res_vld   = 1'b0;
        n_res_value = r_res_value;
        n_res_pos   = r_res_pos;
        n_res_cnt   = r_res_cnt;
        n_res_full  = r_res_full;
        w_ins       = 1'b0;
        w_ins_value = r_value;
        w_wr_en     = 1'b0;
        o_pop       = 1'b0;

        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    unique case (i_q_entry.op)
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_FIRST: begin
                            w_ins       = 1'b1;
                            w_ins_value = i_q_entry.value;
                        end
                        OP_SECOND: begin
                            if (r_count == '0) begin
                                w_ins       = 1'b1;
                                w_ins_value = i_q_entry.value;
                            end else begin
                                n_value = i_q_entry.value;
                                n_idx   = '0;
                                n_state = BS_SCAN;
                            end
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            BS_SCAN: begin
                // Compare last cycle's read while issuing the next one
                if (r_rd_vld && (r_rd_data == r_value)) begin
                    n_state = BS_IDLE;
                end else if (r_idx == r_count) begin
                    w_ins   = 1'b1;
                    n_state = BS_IDLE;
                end else begin
                    n_idx    = r_idx + CNT_W'(1);
                    n_rd_vld = 1'b1;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase

        // Insert: store if there is room, emit either way
        if (w_ins) begin
            n_res_vld   = 1'b1;
            n_res_value = w_ins_value;
            if (r_count < CNT_W'(CAPACITY)) begin
                w_wr_en    = 1'b1;
                n_count    = r_count + CNT_W'(1);
                n_res_pos  = w_cnt_ext[POS_W-1:0];
                n_res_cnt  = w_inc_ext[UCNT_W-1:0];
                n_res_full = 1'b0;
            end else begin
                n_res_pos  = '0;
                n_res_cnt  = w_cnt_ext[UCNT_W-1:0];
                n_res_full = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_res_vld <= n_res_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_res_value <= n_res_value;
        r_res_pos   <= n_res_pos;
        r_res_cnt   <= n_res_cnt;
        r_res_full  <= n_res_full;
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[AW-1:0]] <= w_ins_value;
        end
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    assign o_result_valid = r_res_vld;
    assign o_out_value    = r_res_value;
    assign o_out_position = r_res_pos;
    assign o_union_count  = r_res_cnt;
    assign o_store_full   = r_res_full;

endmodule

// ===== design/set_union_dedup_engine.sv =====
// Union builder for two integer lists, one element per item.
// Input: drive i_cmd and i_item_value with start high; the item is taken at
// the clock edge where start is high and busy is low. cmd 0 clears the union,
// cmd 1 adds a first-list element (added without a search), cmd 2 adds a second-list
// element only when no stored entry equals it, cmd 3 is taken and ignored.
// Output: o_result_valid is high for exactly one cycle per emitted element,
// with value, position, count after the step and the full flag. There is no
// back-pressure on the result side; results are never held.
// Items go through a two-entry queue to the execution unit, so busy rises only
// when that queue is full.
// A cmd 1 element is written into the queue, popped by the execution unit and
// emitted from its result registers. cmd 0 and cmd 1 items, and cmd 2 items on
// an empty union, need no scan. Otherwise a cmd 2 item scans the store: the
// stored entries are read one per cycle through the store's single read port
// and compared, and a match ends the scan early.
// Reset (synchronous, active low) empties the queue and sets the count to
// zero; stored values are not cleared and need no clearing pass.
module set_union_dedup_engine
    import sud_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [VALUE_W-1:0] i_item_value,
    output logic               o_result_valid,
    output logic [VALUE_W-1:0] o_out_value,
    output logic [POS_W-1:0]   o_out_position,
    output logic [UCNT_W-1:0]  o_union_count,
    output logic               o_store_full
);

    logic  w_push;
    t_qent w_push_entry;
    logic  w_q_full;
    logic  w_q_valid;
    t_qent w_q_entry;
    logic  w_pop;

    // Front: take and classify items
    sud_front u_front (
        .i_start      (start),
        .i_cmd        (i_cmd),
        .i_item_value (i_item_value),
        .i_q_full     (w_q_full),
        .o_busy       (busy),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    // Decoupling queue
    sud_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    // Back: search, store and emit
    sud_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_entry      (w_q_entry),
        .o_pop          (w_pop),
        .o_result_valid (o_result_valid),
        .o_out_value    (o_out_value),
        .o_out_position (o_out_position),
        .o_union_count  (o_union_count),
        .o_store_full   (o_store_full)
    );

endmodule

// ===== design/sud_checker.sv =====
`include "set_union_dedup_engine_macros.svh"

module sud_checker
    import sud_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_result_valid,
    input logic [POS_W-1:0]  o_out_position,
    input logic [UCNT_W-1:0] o_union_count,
    input logic              o_store_full
);

    // A rejected element reports position zero and the full count
    `SUD_ASSERT_NOW(a_full_result, o_result_valid && o_store_full, (o_out_position == '0) && (o_union_count == UCNT_W'(CAPACITY)), "full result with wrong position or count")

    // A stored element sits just below the new count
    `SUD_ASSERT_NOW(a_stored_pos, o_result_valid && !o_store_full, o_union_count[POS_W-1:0] == POS_W'(o_out_position + POS_W'(1)), "stored element position does not match count")

    // Leaving reset: nothing emitted and room for an item
    `SUD_ASSERT_NOW(a_reset_quiet, $rose(i_rst_n), !o_result_valid && !busy, "activity right after reset")

    // The queue cannot fill up without a new item
    `SUD_ASSERT_NEXT(a_busy_needs_item, !busy && !start, !busy, "busy rose without an item")

endmodule

bind set_union_dedup_engine sud_checker #(.CAPACITY(CAPACITY)) u_sud_checker (.*);
